>>> rtl/avtjc_pkg.sv
// Shared types, codes and the gap-select function of the A/V timestamp jitter corrector.
package avtjc_pkg;

  // Packet kinds on in_mode; any other code is handled like a header.
  localparam logic [1:0] MODE_VIDEO = 2'd0;
  localparam logic [1:0] MODE_AUDIO = 2'd1;
  localparam logic [1:0] MODE_OTHER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_VIDEO_GAP      = 2'd0;
  localparam logic [1:0] REG_DEFAULT_VIDEO_STEP = 2'd1;
  localparam logic [1:0] REG_MAX_AUDIO_GAP      = 2'd2;
  localparam logic [1:0] REG_DEFAULT_AUDIO_STEP = 2'd3;

  localparam int unsigned RAW_W  = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned DIFF_W = RAW_W + 1;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_MAX_VIDEO_GAP      = 16'd100;
  localparam logic [CFG_W-1:0] RST_DEFAULT_VIDEO_STEP = 16'd40;
  localparam logic [CFG_W-1:0] RST_MAX_AUDIO_GAP      = 16'd100;
  localparam logic [CFG_W-1:0] RST_DEFAULT_AUDIO_STEP = 16'd20;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [DIFF_W-1:0] diff_t;   // two's complement raw difference
  typedef logic [1:0]        run_cnt_t;

  // Magnitude of a signed raw difference.
  function automatic diff_t diff_mag(input diff_t d);
    diff_mag = d[DIFF_W-1] ? (~d + diff_t'(1)) : d;
  endfunction

  // Gap as a 64-bit two's complement step: the raw difference when
  // -maxg < d < maxg, else the default step.
  function automatic time_t pick_gap(input diff_t d, input cfg_t maxg, input cfg_t dflt);
    diff_t mag;
    mag = diff_mag(d);
    if (mag >= diff_t'(maxg)) begin
      pick_gap = time_t'(dflt);
    end else begin
      pick_gap = {{(TIME_W-DIFF_W){d[DIFF_W-1]}}, d};
    end
  endfunction

endpackage

>>> rtl/av_timestamp_jitter_corrector_core.sv
// A/V timestamp jitter corrector: top level with input stage, correction logic and result stage.
//
// One media packet (kind + raw 32-bit ms timestamp) per transfer in, one corrected
// timestamp per transfer out, in order. The block takes a transfer every cycle unless
// in_stall is high, which happens while the input register holds a packet and the
// result register is held by out_stall. Each packet goes through the input register
// and then the result register; out_valid rises once the result register holds it.
// The cycle is set by one 64-bit add of the corrected time plus its clamp, fed by
// parallel 33-bit raw differences and gap compares. Configuration writes take effect
// on the next cycle and are meant to be issued while the block is empty.
module av_timestamp_jitter_corrector_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  avtjc_pkg::raw_t       in_raw_time,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output avtjc_pkg::raw_t       out_fixed_time,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  avtjc_pkg::cfg_t       cfg_wdata
);
  import avtjc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t max_video_gap_r, default_video_step_r, max_audio_gap_r, default_audio_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_video_gap_r      <= RST_MAX_VIDEO_GAP;
      default_video_step_r <= RST_DEFAULT_VIDEO_STEP;
      max_audio_gap_r      <= RST_MAX_AUDIO_GAP;
      default_audio_step_r <= RST_DEFAULT_AUDIO_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_VIDEO_GAP:      max_video_gap_r      <= cfg_wdata;
        REG_DEFAULT_VIDEO_STEP: default_video_step_r <= cfg_wdata;
        REG_MAX_AUDIO_GAP:      max_audio_gap_r      <= cfg_wdata;
        REG_DEFAULT_AUDIO_STEP: default_audio_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register -> result register
  // ---------------------------------------------------------------------------
  logic       q_valid_r, q_valid_nxt;
  logic [1:0] q_mode_r;
  raw_t       q_raw_r;
  logic       out_valid_r, out_valid_nxt;
  raw_t       out_time_r;
  logic       adv;      // result register free to load this cycle
  logic       in_acc;   // input transfer
  logic       fire;     // item in input register is processed

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = q_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = q_valid_r && adv;

  assign q_valid_nxt   = in_acc ? 1'b1 : (adv ? 1'b0 : q_valid_r);
  assign out_valid_nxt = adv ? q_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_mode_r <= in_mode;
      q_raw_r  <= in_raw_time;
    end
  end

  // ---------------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------------
  logic     video_seen_r, audio_seen_r;
  raw_t     last_video_raw_r, last_audio_raw_r;
  time_t    video_out_time_r, audio_out_time_r;
  run_cnt_t audio_run_count_r;

  // ---------------------------------------------------------------------------
  // Correction logic
  // ---------------------------------------------------------------------------
  logic  is_video, is_audio;
  diff_t dv, da;            // raw - last video raw, raw - last audio raw
  time_t gap_vv;            // video-limited gap against last video raw
  time_t gap_va;            // video-limited gap against last audio raw
  time_t gap_aa;            // audio-limited gap against last audio raw
  time_t gap_zero;          // video-limited gap of a zero difference
  logic  rebase;            // first video jumps onto the audio timeline
  logic  audio_first;       // first audio packet since the last video
  time_t base, gap, sum, corr;
  raw_t  res_time;

  assign is_video = (q_mode_r == MODE_VIDEO);
  assign is_audio = (q_mode_r == MODE_AUDIO);

  assign dv = {1'b0, q_raw_r} - {1'b0, last_video_raw_r};
  assign da = {1'b0, q_raw_r} - {1'b0, last_audio_raw_r};

  assign gap_vv   = pick_gap(dv, max_video_gap_r, default_video_step_r);
  assign gap_va   = pick_gap(da, max_video_gap_r, default_video_step_r);
  assign gap_aa   = pick_gap(da, max_audio_gap_r, default_audio_step_r);
  assign gap_zero = pick_gap('0, max_video_gap_r, default_video_step_r);

  // |last_audio_raw - raw| equals |da|
  assign rebase      = audio_seen_r && (diff_mag(da) >= diff_t'(max_video_gap_r));
  assign audio_first = (audio_run_count_r == 2'd0);

  // One shared adder; each packet kind picks its base and step.
  always_comb begin
    base = time_t'(q_raw_r);
    gap  = '0;
    if (is_video) begin
      if (video_seen_r) begin
        base = video_out_time_r;
        gap  = gap_vv;
      end else if (rebase) begin
        base = audio_out_time_r;
        gap  = gap_va;
      end else begin
        gap  = gap_zero;
      end
    end else if (is_audio) begin
      if (audio_first) begin
        // tie to the video timeline when there is one
        if (video_seen_r) begin
          base = video_out_time_r;
          gap  = gap_vv;
        end
      end else if (audio_seen_r) begin
        base = audio_out_time_r;
        gap  = gap_aa;
      end
    end
  end

  assign sum  = base + gap;
  assign corr = sum[TIME_W-1] ? '0 : sum;     // negative clamps to zero
  assign res_time = (is_video || is_audio) ? corr[RAW_W-1:0] : '0;

  // ---------------------------------------------------------------------------
  // State update and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_seen_r      <= 1'b0;
      audio_seen_r      <= 1'b0;
      last_video_raw_r  <= '0;
      last_audio_raw_r  <= '0;
      video_out_time_r  <= '0;
      audio_out_time_r  <= '0;
      audio_run_count_r <= '0;
    end else if (fire) begin
      if (is_video) begin
        video_seen_r      <= 1'b1;
        last_video_raw_r  <= q_raw_r;
        video_out_time_r  <= corr;
        audio_run_count_r <= '0;
      end else if (is_audio) begin
        audio_seen_r     <= 1'b1;
        last_audio_raw_r <= q_raw_r;
        audio_out_time_r <= corr;
        if (audio_run_count_r != 2'd2) begin
          audio_run_count_r <= audio_run_count_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_time_r <= res_time;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fixed_time = out_time_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_valid_r && out_valid_r))
    else $error("input stalled with nothing held");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_video && !is_audio) |=> (out_fixed_time == '0))
    else $error("header result not zero");

  a_video_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(video_seen_r))
    else $error("video_seen cleared");

  a_video_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_video) |=> (audio_run_count_r == 2'd0))
    else $error("audio run count not cleared by video");

  a_audio_marks_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_audio) |=> (audio_seen_r && audio_run_count_r != 2'd0))
    else $error("audio packet did not update audio state");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the A/V timestamp jitter corrector core.
module tb;
  import avtjc_pkg::*;

  // in_mode code 3 has no name in the package; the core treats it as a header.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Audio run counter stops counting here.
  localparam run_cnt_t RUN_SAT = 2'd2;
  // Only the first few mismatches get printed in full.
  localparam int unsigned SHOW_LIMIT = 10;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode     = MODE_OTHER;
  raw_t       in_raw_time = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  raw_t       out_fixed_time;
  logic       cfg_we      = 1'b0;
  logic [1:0] cfg_index   = REG_MAX_VIDEO_GAP;
  cfg_t       cfg_wdata   = '0;

  av_timestamp_jitter_corrector_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_raw_time    (in_raw_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fixed_time (out_fixed_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (~1100 packets).
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: mirror of the core's correction state and registers
  // ---------------------------------------------------------------------------
  cfg_t     lim_video  = RST_MAX_VIDEO_GAP;
  cfg_t     step_video = RST_DEFAULT_VIDEO_STEP;
  cfg_t     lim_audio  = RST_MAX_AUDIO_GAP;
  cfg_t     step_audio = RST_DEFAULT_AUDIO_STEP;

  logic     have_video     = 1'b0;
  raw_t     video_last_raw = '0;
  time_t    video_time     = '0;
  logic     have_audio     = 1'b0;
  raw_t     audio_last_raw = '0;
  time_t    audio_time     = '0;
  run_cnt_t audio_run      = '0;

  // Corrected times never go negative.
  function automatic time_t clamp_time(input time_t v);
    return v[TIME_W-1] ? '0 : v;
  endfunction

  // Signed raw gap now - prev, or the default step when |gap| >= lim.
  // lim == 0 means nothing is in range.
  function automatic time_t gap_step(input raw_t now, input raw_t prev,
                                     input cfg_t lim, input cfg_t dflt);
    time_t d, mag;
    d   = time_t'(now) - time_t'(prev);
    mag = d[TIME_W-1] ? -d : d;
    if (lim == '0 || mag >= time_t'(lim)) return time_t'(dflt);
    return d;
  endfunction

  // Advance the predictor by one packet and return the expected fixed_time.
  function automatic raw_t predict_fixed_time(input logic [1:0] mode, input raw_t raw);
    time_t diff, mag;
    case (mode)
      MODE_VIDEO: begin
        audio_run = '0;
        if (!have_video) begin
          // first video: start on its own raw time, or re-base on audio when the
          // full-width audio/video distance is too large
          have_video     = 1'b1;
          video_last_raw = raw;
          video_time     = time_t'(raw);
          if (have_audio) begin
            diff = time_t'(audio_last_raw) - time_t'(raw);
            mag  = diff[TIME_W-1] ? -diff : diff;
            if (mag >= time_t'(lim_video)) begin
              video_last_raw = audio_last_raw;
              video_time     = audio_time;
            end
          end
        end
        video_time = clamp_time(video_time +
                                gap_step(raw, video_last_raw, lim_video, step_video));
        video_last_raw = raw;
        return video_time[RAW_W-1:0];
      end
      MODE_AUDIO: begin
        if (audio_run != RUN_SAT) audio_run = audio_run + 1'b1;
        if (audio_run == RUN_SAT && have_audio) begin
          audio_time = clamp_time(audio_time +
                                  gap_step(raw, audio_last_raw, lim_audio, step_audio));
        end else if (audio_run == RUN_SAT || !have_video) begin
          audio_time = time_t'(raw);
        end else begin
          // first audio after video: tied to the video time line
          audio_time = clamp_time(video_time +
                                  gap_step(raw, video_last_raw, lim_video, step_video));
        end
        have_audio     = 1'b1;
        audio_last_raw = raw;
        return audio_time[RAW_W-1:0];
      end
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  raw_t        fixed_time_due[$];   // expected fixed_time, oldest first
  int unsigned fault_count   = 0;
  int unsigned checked_count = 0;
  int unsigned video_sent    = 0;
  int unsigned audio_sent    = 0;
  int unsigned header_sent   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  task automatic note_fault(input string what, input raw_t want, input raw_t got);
    fault_count++;
    if (fault_count <= SHOW_LIMIT)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Receiver: random stall, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // A result transfer happens when out_valid is high and out_stall low at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (fixed_time_due.size() == 0) begin
        note_fault("transfer with nothing outstanding", '0, out_fixed_time);
      end else begin
        if (out_fixed_time !== fixed_time_due[0])
          note_fault("fixed_time", fixed_time_due[0], out_fixed_time);
        void'(fixed_time_due.pop_front());
        checked_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one packet, hold it until the transfer, then record the prediction.
  // valid stays high on return so back-to-back packets need no bubble.
  task automatic send_packet(input logic [1:0] mode, input raw_t raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_raw_time <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fixed_time_due.push_back(predict_fixed_time(mode, raw));
    case (mode)
      MODE_VIDEO: video_sent++;
      MODE_AUDIO: audio_sent++;
      default:    header_sent++;
    endcase
  endtask

  // Stop sending and let the pipe drain (two-stage core).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fixed_time_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back while the core is empty.
  task automatic apply_config(input cfg_t mvg, input cfg_t dvs,
                              input cfg_t mag, input cfg_t das);
    logic [1:0] idx[4];
    cfg_t       val[4];
    idx = '{REG_MAX_VIDEO_GAP, REG_DEFAULT_VIDEO_STEP,
            REG_MAX_AUDIO_GAP, REG_DEFAULT_AUDIO_STEP};
    val = '{mvg, dvs, mag, das};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    lim_video  = mvg;
    step_video = dvs;
    lim_audio  = mag;
    step_audio = das;
    repeat (2) @(posedge clk);
  endtask

  // Stream clocks for the well-formed traffic
  raw_t vid_clock = '0;
  raw_t aud_clock = '0;

  // Next raw time of a stream: mostly nominal cadence with jitter, sometimes
  // small backward steps, medium/large jumps or a fully random value.
  function automatic raw_t advance_clock(input raw_t base, input int unsigned cadence);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return base + cadence + $urandom_range(0, 16) - 8;
    if (roll < 78) return base - $urandom_range(0, 120);
    if (roll < 90) return base + $urandom_range(0, 70000);
    if (roll < 95) return base - $urandom_range(0, 70000);
    return $urandom();
  endfunction

  // One packet of interleaved A/V traffic, with some headers as noise.
  task automatic send_stream_packet();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_packet(2'($urandom_range(MODE_OTHER, MODE_SPARE)), $urandom());
    end else if (roll < 52) begin
      vid_clock = advance_clock(vid_clock, 33);
      send_packet(MODE_VIDEO, vid_clock);
    end else begin
      // re-align audio with video now and then so cross gaps stay in range
      if ($urandom_range(0, 9) == 0) aud_clock = vid_clock;
      aud_clock = advance_clock(aud_clock, 23);
      send_packet(MODE_AUDIO, aud_clock);
    end
  endtask

  // Gap limit: mostly modest, sometimes zero (nothing in range) or full scale.
  function automatic cfg_t pick_limit();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return cfg_t'($urandom_range(1, 400));
  endfunction

  function automatic cfg_t pick_step();
    return ($urandom_range(0, 1) != 0) ? cfg_t'($urandom_range(0, 100))
                                       : cfg_t'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed packets at reset settings. The first video packet can only be seen
  // once per run, so a coin decides whether it re-bases on audio or not.
  task automatic test_directed();
    raw_t last_v;
    send_packet(MODE_OTHER, '1);              // headers before any media
    send_packet(MODE_SPARE, 32'hA5A5_A5A5);
    if ($urandom_range(0, 1) != 0) begin
      // far: audio starts on raw, first video lands far off and re-bases
      send_packet(MODE_AUDIO, 32'd0);         // audio before video: raw time
      send_packet(MODE_AUDIO, 32'd5000);      // out of range: default step
      send_packet(MODE_AUDIO, 32'd5099);      // just inside
      send_packet(MODE_AUDIO, 32'd5000);      // negative, just inside
      send_packet(MODE_AUDIO, 32'd4900);      // -100: on the limit, default
      send_packet(MODE_VIDEO, 32'd9000);      // first video, re-based on audio
      send_packet(MODE_VIDEO, 32'd8910);      // negative step below zero: clamp
      last_v = 32'd8910;
    end else begin
      // near: audio starts high and wraps past 2^32, first video lands close
      send_packet(MODE_AUDIO, 32'hFFFF_FFC0);
      send_packet(MODE_AUDIO, 32'hFFFF_FFE0);
      send_packet(MODE_AUDIO, 32'h0000_0010); // raw wrap: huge gap, default
      send_packet(MODE_AUDIO, 32'h0000_0060); // corrected time crosses 2^32
      send_packet(MODE_AUDIO, 32'h0000_00C4); // gap exactly 100: default
      send_packet(MODE_VIDEO, 32'h0000_00A0); // first video, no re-base
      send_packet(MODE_VIDEO, 32'd1000);
      send_packet(MODE_VIDEO, 32'd920);
      send_packet(MODE_VIDEO, 32'd840);
      send_packet(MODE_VIDEO, 32'd760);       // goes negative: clamp
      last_v = 32'd760;
    end
    send_packet(MODE_AUDIO, last_v + 40);     // first audio after video: tied
    send_packet(MODE_AUDIO, last_v + 60);     // second audio: audio gap
    send_packet(MODE_AUDIO, '1);
    send_packet(MODE_AUDIO, '0);
    send_packet(MODE_VIDEO, 32'hFFFF_FFF0);
    send_packet(MODE_VIDEO, '0);
    send_packet(MODE_OTHER, '1);              // header mid-stream
    send_packet(MODE_SPARE, 32'h5A5A_5A5A);
    send_packet(MODE_VIDEO, 32'd99);
    send_packet(MODE_AUDIO, 32'd99);
    wait_idle();
  endtask

  // Register extremes: all zero, all ones, minimal limits, random, then reset values.
  task automatic test_register_extremes();
    cfg_t sets[5][4];
    sets = '{'{16'd0, 16'd0, 16'd0, 16'd0},
             '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
             '{16'd1, 16'd7, 16'd1, 16'd3},
             '{pick_limit(), pick_step(), pick_limit(), pick_step()},
             '{RST_MAX_VIDEO_GAP, RST_DEFAULT_VIDEO_STEP,
               RST_MAX_AUDIO_GAP, RST_DEFAULT_AUDIO_STEP}};
    vid_clock = video_last_raw;
    aud_clock = video_last_raw;
    foreach (sets[s]) begin
      apply_config(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
      repeat (30) send_stream_packet();
    end
    wait_idle();
  endtask

  // Bulk random traffic in three handshake regimes, new registers each time.
  task automatic test_random_traffic();
    int unsigned send_pct[3];
    int unsigned recv_pct[3];
    send_pct = '{25, 79, 0};
    recv_pct = '{79, 25, 0};
    for (int p = 0; p < 3; p++) begin
      apply_config(pick_limit(), pick_step(), pick_limit(), pick_step());
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (300) send_stream_packet();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed and register tests run with the sender at 25% idle, receiver at 79%
    send_idle_pct  = 25;
    recv_stall_pct = 79;
    test_directed();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d video, %0d audio and %0d header packets over reset and eight written register sets;",
             video_sent, audio_sent, header_sent);
    $display("%0d corrected times compared, %0d faults.", checked_count, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
